>>> rtl/core/pcicfg_pkg.sv
package pcicfg_pkg;

    // Transaction kinds carried on the input tuser
    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_REINIT = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DEVICE_SELECT = 3'd0;
    localparam logic [2:0] REG_BAR0_RESET    = 3'd1;
    localparam logic [2:0] REG_BAR5_RESET    = 3'd6;

    localparam int unsigned NUM_BARS = 6;

    // Header word indexes
    localparam logic [5:0] WORD_ID        = 6'd0;
    localparam logic [5:0] WORD_CMD_STAT  = 6'd1;
    localparam logic [5:0] WORD_CLASS     = 6'd2;
    localparam logic [5:0] WORD_MISC      = 6'd3;
    localparam logic [5:0] WORD_BAR0      = 6'd4;
    localparam logic [5:0] WORD_BAR3      = 6'd7;
    localparam logic [5:0] WORD_BAR5      = 6'd9;
    localparam logic [5:0] WORD_CARDBUS   = 6'd10;
    localparam logic [5:0] WORD_SUBSYS    = 6'd11;
    localparam logic [5:0] WORD_ROM       = 6'd12;
    localparam logic [5:0] WORD_CAP       = 6'd13;
    localparam logic [5:0] WORD_RSVD      = 6'd14;
    localparam logic [5:0] WORD_INT       = 6'd15;

    localparam logic [31:0] SEL_MASK        = 32'h7FFF_FF00;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_8M         = 32'hFF80_0000;
    localparam logic [31:0] MASK_64K        = 32'hFFFF_0000;
    localparam logic [31:0] ID_WORD         = 32'h4026_110A;
    localparam logic [31:0] CMD_STATUS_INIT = 32'h0200_0007;
    localparam logic [31:0] CLASS_INIT      = 32'h0200_0000;
    localparam logic [31:0] INTPIN_INIT     = 32'h0000_0100;

    // Size mask of a BAR by its position 0..5
    function automatic logic [31:0] bar_mask(input logic [2:0] idx);
        return (idx == 3'd3) ? MASK_8M : MASK_64K;
    endfunction

endpackage

>>> rtl/core/pci_config_header_bar_probe_unit.sv
// Channel  | Dir | Handshake                | Payload
// s_axis   | in  | s_axis_tvalid/tready     | tdata: cfg_address, write_data; tuser: mode
// m_axis   | out | m_axis_tvalid/tready     | tdata: read_data; tuser: write_handled
// apb      | in  | psel/penable, pready = 1 | paddr, pwdata, prdata (7 registers)
//
// One transaction per cycle sustained while m_axis is ready: an input register and a
// result register with the header lookup and update between them.
// rst_n (async, active low) loads the header defaults and clears the probe flags.
// A stall on m_axis holds the result; the input register still takes one more
// transaction before s_axis_tready drops.
module pci_config_header_bar_probe_unit
    import pcicfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] cfg_address, [63:32] write_data
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_data
    output logic [0:0]  m_axis_tuser,   // [0] write_handled
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [30:0] device_select_reg;
    logic [31:0] bar_reset_reg [NUM_BARS];

    logic        in_valid_reg;
    logic [1:0]  in_mode_reg;
    logic [31:0] in_addr_reg;
    logic [31:0] in_data_reg;

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_handled_reg;

    // Writable header state; the rest of the header is constant
    logic [15:0] cmd_low_reg;
    logic [15:0] misc_low_reg;
    logic [7:0]  int_low_reg;
    logic [31:0] bar_reg [NUM_BARS];
    logic [NUM_BARS-1:0] probe_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        advance;
    logic        do_op;
    logic [5:0]  word;
    logic [5:0]  bar_off;
    logic [2:0]  bar_idx;
    logic        hit;
    logic [31:0] rd_word;
    logic [31:0] rd_data;
    logic        handled;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == REG_DEVICE_SELECT)
        begin
            prdata = {1'b0, device_select_reg};
        end
        else if (cfg_idx <= REG_BAR5_RESET)
        begin
            prdata = bar_reset_reg[cfg_idx - REG_BAR0_RESET];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_select_reg <= '0;
            for (int i = 0; i < NUM_BARS; i++)
            begin
                bar_reset_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == REG_DEVICE_SELECT)
            begin
                device_select_reg <= pwdata[30:0];
            end
            else if (cfg_idx <= REG_BAR5_RESET)
            begin
                bar_reset_reg[cfg_idx - REG_BAR0_RESET] <= pwdata;
            end
        end
    end

    // Pipeline control: advance when the result register is free or drains
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign do_op         = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg <= s_axis_tuser;
            in_addr_reg <= s_axis_tdata[31:0];
            in_data_reg <= s_axis_tdata[63:32];
        end
    end

    // Decode the address
    assign word    = in_addr_reg[7:2];
    assign bar_off = word - WORD_BAR0;
    assign bar_idx = bar_off[2:0];
    assign hit     = (in_addr_reg & SEL_MASK) == {1'b0, device_select_reg};

    // Header read
    always_comb
    begin
        case (word) inside
            WORD_ID, WORD_SUBSYS:
                rd_word = ID_WORD;
            WORD_CMD_STAT:
                rd_word = {CMD_STATUS_INIT[31:16], cmd_low_reg};
            WORD_CLASS:
                rd_word = CLASS_INIT;
            WORD_MISC:
                rd_word = {16'h0000, misc_low_reg};
            [WORD_BAR0:WORD_BAR5]:
                rd_word = probe_reg[bar_idx] ? bar_mask(bar_idx) : bar_reg[bar_idx];
            WORD_INT:
                rd_word = {INTPIN_INIT[31:8], int_low_reg};
            default:
                rd_word = '0;
        endcase
    end

    always_comb
    begin
        rd_data = '0;
        handled = 1'b0;
        case (in_mode_reg)
            MODE_READ:
                rd_data = hit ? rd_word : ALL_ONES;
            MODE_WRITE:
                handled = !hit || (word <= WORD_INT);
            default:
            begin
                rd_data = '0;
                handled = 1'b0;
            end
        endcase
    end

    // Header update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_low_reg  <= CMD_STATUS_INIT[15:0];
            misc_low_reg <= '0;
            int_low_reg  <= INTPIN_INIT[7:0];
            probe_reg    <= '0;
            for (int i = 0; i < NUM_BARS; i++)
            begin
                bar_reg[i] <= '0;
            end
        end
        else if (do_op)
        begin
            if (in_mode_reg == MODE_REINIT)
            begin
                cmd_low_reg  <= CMD_STATUS_INIT[15:0];
                misc_low_reg <= '0;
                int_low_reg  <= INTPIN_INIT[7:0];
                probe_reg    <= '0;
                for (int i = 0; i < NUM_BARS; i++)
                begin
                    bar_reg[i] <= bar_reset_reg[i];
                end
            end
            else if (in_mode_reg == MODE_WRITE && hit)
            begin
                case (word) inside
                    WORD_CMD_STAT:
                        cmd_low_reg <= in_data_reg[15:0];
                    WORD_MISC:
                        misc_low_reg <= in_data_reg[15:0];
                    WORD_INT:
                        int_low_reg <= in_data_reg[7:0];
                    [WORD_BAR0:WORD_BAR5]:
                    begin
                        probe_reg[bar_idx] <= (in_data_reg == ALL_ONES);
                        if (in_data_reg != ALL_ONES)
                        begin
                            bar_reg[bar_idx] <= in_data_reg & bar_mask(bar_idx);
                        end
                    end
                    default:
                    begin
                        // read-only, self-clearing or absent words: nothing stored
                    end
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_op)
        begin
            out_data_reg    <= rd_data;
            out_handled_reg <= handled;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_handled_reg;

    // Reinitialize leaves every BAR out of probe mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_op && in_mode_reg == MODE_REINIT) |=> (probe_reg == '0))
        else $error("probe flags not cleared by reinitialize");

    // An all-ones write to the selected BAR3 arms its probe flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_op && in_mode_reg == MODE_WRITE && hit && word == WORD_BAR3
            && in_data_reg == ALL_ONES) |=> probe_reg[3])
        else $error("BAR probe not armed");

    // A result marked handled never carries read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_handled_reg) |-> (out_data_reg == '0))
        else $error("write result carries read data");

    // Both stages full and output stalled: input must be held off
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted with full pipeline");

endmodule

>>> test/pcicfg_header_checker.sv
module pcicfg_header_checker
    import pcicfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] cfg_address, [63:32] write_data
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] read_data
    input  logic [0:0]  m_axis_tuser,   // [0] write_handled
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] read_data;
        logic        write_handled;
    } cfg_reply_t;

    // Shadow copy of the register file and the header
    logic [30:0] sel_shadow;
    logic [31:0] bar_init_shadow [NUM_BARS];
    logic [31:0] hdr_shadow [16];
    logic        probe_shadow [NUM_BARS];

    cfg_reply_t expected_replies [$];
    cfg_reply_t got_reply;
    cfg_reply_t want_reply;
    cfg_reply_t next_reply;
    int         errors = 0;

    function automatic logic [31:0] bar_size_mask(input logic [5:0] w);
        return (w == WORD_BAR3) ? MASK_8M : MASK_64K;
    endfunction

    // Rebuild the header defaults from the shadow BAR init values
    task automatic reload_header();
        for (int i = 0; i < 16; i++)
            hdr_shadow[i] = '0;
        for (int b = 0; b < NUM_BARS; b++)
        begin
            hdr_shadow[WORD_BAR0 + b] = bar_init_shadow[b];
            probe_shadow[b] = 1'b0;
        end
        hdr_shadow[WORD_ID]       = ID_WORD;
        hdr_shadow[WORD_CMD_STAT] = CMD_STATUS_INIT;
        hdr_shadow[WORD_CLASS]    = CLASS_INIT;
        hdr_shadow[WORD_SUBSYS]   = ID_WORD;
        hdr_shadow[WORD_INT]      = INTPIN_INIT;
    endtask

    // Apply one configuration access to the shadow header and form its reply
    task automatic predict_cfg_access(input logic [1:0] mode, input logic [31:0] addr,
                                      input logic [31:0] data, output cfg_reply_t reply);
        logic [5:0] w;
        logic       hit;
        int         b;
        w = addr[7:2];
        hit = ((addr & SEL_MASK) == {1'b0, sel_shadow});
        reply = '0;
        case (mode)
            MODE_READ:
            begin
                if (!hit)
                    reply.read_data = ALL_ONES;
                else if (w > WORD_INT)
                    reply.read_data = '0;
                else if (w >= WORD_BAR0 && w <= WORD_BAR5 && probe_shadow[w - WORD_BAR0])
                    reply.read_data = bar_size_mask(w);
                else
                    reply.read_data = hdr_shadow[w[3:0]];
            end
            MODE_WRITE:
            begin
                reply.write_handled = 1'b1;
                if (hit)
                begin
                    if (w > WORD_INT)
                        reply.write_handled = 1'b0;
                    else if (w >= WORD_BAR0 && w <= WORD_BAR5)
                    begin
                        // All ones arms the sizing probe, anything else stores masked
                        b = w - WORD_BAR0;
                        probe_shadow[b] = (data == ALL_ONES);
                        if (!probe_shadow[b])
                            hdr_shadow[w[3:0]] = data & bar_size_mask(w);
                    end
                    else
                    begin
                        case (w)
                            WORD_CMD_STAT, WORD_MISC:
                                hdr_shadow[w[3:0]] = {hdr_shadow[w[3:0]][31:16], data[15:0]};
                            WORD_ROM, WORD_CAP:
                                hdr_shadow[w[3:0]] = '0;
                            WORD_INT:
                                hdr_shadow[w[3:0]] = {hdr_shadow[w[3:0]][31:8], data[7:0]};
                            default:
                                ;
                        endcase
                    end
                end
            end
            MODE_REINIT:
                reload_header();
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_shadow = '0;
            for (int b = 0; b < NUM_BARS; b++)
                bar_init_shadow[b] = '0;
            reload_header();
            expected_replies.delete();
            pending <= 0;
        end
        else
        begin
            // Compare a finished transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_reply.read_data     = m_axis_tdata;
                got_reply.write_handled = m_axis_tuser[0];
                if (expected_replies.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result read_data %h write_handled %b",
                                 $realtime, got_reply.read_data, got_reply.write_handled);
                end
                else
                begin
                    want_reply = expected_replies.pop_front();
                    if (got_reply.read_data !== want_reply.read_data
                        || got_reply.write_handled !== want_reply.write_handled)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch read_data exp %h got %h, write_handled exp %b got %b",
                                     $realtime, want_reply.read_data, got_reply.read_data,
                                     want_reply.write_handled, got_reply.write_handled);
                    end
                end
            end

            // Predict each accepted request
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_cfg_access(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                                   next_reply);
                expected_replies.push_back(next_reply);
            end

            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[4:2] == REG_DEVICE_SELECT)
                    sel_shadow = pwdata[30:0];
                else if (paddr[4:2] >= REG_BAR0_RESET && paddr[4:2] <= REG_BAR5_RESET)
                    bar_init_shadow[paddr[4:2] - REG_BAR0_RESET] = pwdata;
            end

            pending <= expected_replies.size();
        end
        fail_count <= errors;
    end

endmodule

>>> test/tb_top.sv
module tb_top;
    import pcicfg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum {BARS_ZERO, BARS_ONES, BARS_RANDOM} bar_fill_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // [31:0] cfg_address, [63:32] write_data
    logic [1:0]  s_axis_tuser = '0;    // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] read_data
    logic [0:0]  m_axis_tuser;         // [0] write_handled
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_replies;
    int          cycles = 0;
    int          sent = 0;
    bit          send_calm = 1'b0;
    logic [30:0] cur_sel = '0;

    always #5 clk = ~clk;

    pci_config_header_bar_probe_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pcicfg_header_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending_replies)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls per transaction, with calm stretches
    initial
    begin
        int  gap;
        int  taken;
        bit  calm;
        taken = 0;
        calm = 1'b0;
        @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    function automatic logic [31:0] word_addr(input logic [5:0] w);
        return {1'b0, cur_sel[30:8], w, 2'b00};
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_item(input logic [1:0] mode, input logic [31:0] addr,
                             input logic [31:0] data);
        int gap;
        if (sent % 32 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= mode;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    // Stop sending and wait until every predicted result has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program the select and all BAR init values, then reload the header
    task automatic configure(input logic [31:0] sel, input bar_fill_t fill);
        logic [31:0] v;
        apb_write(REG_DEVICE_SELECT, sel);
        cur_sel = sel[30:0];
        for (int b = 0; b < NUM_BARS; b++)
        begin
            case (fill)
                BARS_ZERO: v = '0;
                BARS_ONES: v = ALL_ONES;
                default:   v = $urandom;
            endcase
            apb_write(3'(REG_BAR0_RESET + b), v);
        end
        send_item(MODE_REINIT, word_addr(WORD_ID), $urandom);
    endtask

    task automatic random_item();
        logic [1:0]  mode;
        logic [31:0] addr;
        logic [31:0] data;
        logic [5:0]  w;
        int          pick;
        pick = $urandom_range(0, 99);
        mode = (pick < 45) ? MODE_READ : (pick < 90) ? MODE_WRITE :
               (pick < 98) ? MODE_REINIT : MODE_NOP;
        w = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 15))
                                       : 6'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 85)
        begin
            addr = word_addr(w);
            addr[31] = 1'($urandom_range(0, 1));
            addr[1:0] = 2'($urandom_range(0, 3));
        end
        else
            addr = $urandom;
        pick = $urandom_range(0, 99);
        data = (pick < 25) ? ALL_ONES : (pick < 30) ? 32'h0 : $urandom;
        send_item(mode, addr, data);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on reset defaults
        send_item(MODE_READ,  word_addr(WORD_ID), 32'h0);
        send_item(MODE_READ,  word_addr(WORD_CMD_STAT), 32'h0);
        send_item(MODE_READ,  word_addr(WORD_BAR0), 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_BAR3), ALL_ONES);
        send_item(MODE_READ,  word_addr(WORD_BAR3), 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_BAR0), ALL_ONES);
        send_item(MODE_READ,  word_addr(WORD_BAR0), 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_BAR3), 32'hFFFF_FFFE);
        send_item(MODE_READ,  word_addr(WORD_BAR3), 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_CMD_STAT), ALL_ONES);
        send_item(MODE_READ,  word_addr(WORD_CMD_STAT), 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_INT), ALL_ONES);
        send_item(MODE_READ,  word_addr(WORD_INT), 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_ROM), ALL_ONES);
        send_item(MODE_READ,  word_addr(WORD_ROM), 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_ID), 32'h0);
        send_item(MODE_READ,  word_addr(WORD_ID), 32'h0);
        send_item(MODE_WRITE, word_addr(6'd16), ALL_ONES);
        send_item(MODE_READ,  word_addr(6'd63), 32'h0);
        send_item(MODE_READ,  word_addr(WORD_ID) | 32'h0000_0100, 32'h0);
        send_item(MODE_WRITE, word_addr(WORD_MISC) | 32'h4000_0000, ALL_ONES);
        send_item(MODE_READ,  32'h8000_0007, 32'h0);
        send_item(MODE_REINIT, ALL_ONES, ALL_ONES);
        send_item(MODE_READ,  word_addr(WORD_BAR3), 32'h0);
        send_item(MODE_NOP,   ALL_ONES, ALL_ONES);
        drain_results();

        // Random phases over several register settings
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: configure(32'h7FFF_FF00, BARS_ONES);
                1: configure({1'b0, 23'($urandom), 8'h00}, BARS_RANDOM);
                2: configure(32'hFFFF_FFFF, BARS_ZERO);
                default: configure($urandom & SEL_MASK, BARS_RANDOM);
            endcase
            for (int n = 0; n < ((p == 2) ? 40 : 150); n++)
            begin
                random_item();
                // Hold off once mid-phase until the pipeline is empty
                if (p == 1 && n == 70)
                    drain_results();
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
